// File: sv/sensor_series_statistics_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor series statistics unit
// Immediate-consequence and next-cycle property wrappers; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef SENSOR_SERIES_STATISTICS_UNIT_MACROS_SVH
`define SENSOR_SERIES_STATISTICS_UNIT_MACROS_SVH

`ifndef SYNTH

`define SSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define SSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define SSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the sensor series statistics unit.
// ----------------------------------------------------------------------------
package sss_pkg;

	// configuration register map
	localparam int NUM_REGS = 8;
	localparam int ADDR_W   = 5;

	localparam logic [2:0] REG_VALID_LOW      = 3'd0;
	localparam logic [2:0] REG_VALID_HIGH     = 3'd1;
	localparam logic [2:0] REG_FROST_BELOW    = 3'd2;
	localparam logic [2:0] REG_HEAT_ABOVE     = 3'd3;
	localparam logic [2:0] REG_FREEZING_LIMIT = 3'd4;
	localparam logic [2:0] REG_COOL_LIMIT     = 3'd5;
	localparam logic [2:0] REG_MILD_LIMIT     = 3'd6;
	localparam logic [2:0] REG_WARM_LIMIT     = 3'd7;

	localparam int REG_RESET [NUM_REGS] = '{-800, 800, 0, 480, 0, 240, 400, 560};

	// input kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_END    = 1'b1;

	// result status codes
	localparam logic [2:0] STAT_ACCEPTED = 3'd0;
	localparam logic [2:0] STAT_RANGE    = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_REPORT   = 3'd3;
	localparam logic [2:0] STAT_EMPTY    = 3'd4;

	// class limits are tried in order freezing, cool, mild, warm
	localparam logic [1:0] CLS_FIRST_IDX = 2'd0;
	localparam logic [1:0] CLS_LAST_IDX  = 2'd3;
	localparam logic [2:0] CLASS_HOT     = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CMP,
		ST_WAIT,
		ST_REPORT
	} sss_state_t;

	typedef struct packed {
		logic       sample_step;
		logic       empty_rep;
		logic       div_start;
		logic       mul;
		logic       cmp;
		logic       report;
		logic [1:0] cls_idx;
	} sss_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic out_free;
		logic cls_hit;
		logic div_busy;
	} sss_sts_t;

endpackage

// File: sv/sss_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_regs
// APB register file holding the window, threshold and class limit settings.
// ----------------------------------------------------------------------------
module sss_regs #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                psel,
	input  logic                                                penable,
	input  logic                                                pwrite,
	input  logic [sss_pkg::ADDR_W-1:0]                          paddr,
	input  logic [31:0]                                         pwdata,
	output logic [31:0]                                         prdata,
	output logic                                                pready,
	output logic [sss_pkg::NUM_REGS-1:0][SAMPLE_BITS-1:0]       cfg
);
	import sss_pkg::*;

	logic [NUM_REGS-1:0][SAMPLE_BITS-1:0] cfg_q;
	logic [2:0]                           idx;
	logic                                 wr_en;
	logic [SAMPLE_BITS-1:0]               rd_val;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= SAMPLE_BITS'(REG_RESET[i]);
			end
		end else if (wr_en) begin
			cfg_q[idx] <= pwdata[SAMPLE_BITS-1:0];
		end
	end

	always_comb begin
		case (idx)
			REG_VALID_LOW:      rd_val = cfg_q[REG_VALID_LOW];
			REG_VALID_HIGH:     rd_val = cfg_q[REG_VALID_HIGH];
			REG_FROST_BELOW:    rd_val = cfg_q[REG_FROST_BELOW];
			REG_HEAT_ABOVE:     rd_val = cfg_q[REG_HEAT_ABOVE];
			REG_FREEZING_LIMIT: rd_val = cfg_q[REG_FREEZING_LIMIT];
			REG_COOL_LIMIT:     rd_val = cfg_q[REG_COOL_LIMIT];
			REG_MILD_LIMIT:     rd_val = cfg_q[REG_MILD_LIMIT];
			REG_WARM_LIMIT:     rd_val = cfg_q[REG_WARM_LIMIT];
			default:            rd_val = '0;
		endcase
	end

	// registers read back sign-extended
	assign prdata = 32'($signed(rd_val));
	assign cfg    = cfg_q;

endmodule

// File: sv/sss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sss_div #(
	parameter int DIVIDEND_W = 28,
	parameter int DIVISOR_W  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic                  busy
);
	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top trial bit drops out
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

endmodule

// File: sv/sss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_ctrl
// Sequencer: takes input words, steps the class compares, waits on the
// divider and releases the report.
// ----------------------------------------------------------------------------
module sss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              kind,
	output logic              s_tready,
	input  sss_pkg::sss_sts_t sts,
	output sss_pkg::sss_cmd_t cmd
);
	import sss_pkg::*;

	sss_state_t state_q;
	sss_state_t state_d;
	logic [1:0] cls_idx_q;
	logic       accept;
	logic       cls_done;

	assign accept   = s_tvalid && s_tready;
	assign cls_done = sts.cls_hit || (cls_idx_q == CLS_LAST_IDX);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_END) && !sts.count_zero) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = cls_done ? ST_WAIT : ST_MUL;
			end
			ST_WAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready        = 1'b0;
		cmd             = '0;
		cmd.cls_idx     = cls_idx_q;
		case (state_q)
			ST_IDLE: begin
				s_tready        = sts.out_free;
				cmd.sample_step = accept && (kind == KIND_SAMPLE);
				cmd.empty_rep   = accept && (kind == KIND_END) && sts.count_zero;
				cmd.div_start   = accept && (kind == KIND_END) && !sts.count_zero;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
			end
			ST_WAIT: begin
				s_tready = 1'b0;
			end
			ST_REPORT: begin
				cmd.report = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cls_idx_q <= CLS_FIRST_IDX;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				cls_idx_q <= CLS_FIRST_IDX;
			end else if ((state_q == ST_CMP) && !cls_done) begin
				cls_idx_q <= cls_idx_q + 1'b1;
			end
		end
	end

endmodule

// File: sv/sss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_dp
// Datapath: running statistics, class multiply-compare, mean divider and
// the output word register.
// ----------------------------------------------------------------------------
module sss_dp #(
	parameter int SAMPLE_BITS = 12,
	parameter int COUNT_BITS  = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  sss_pkg::sss_cmd_t                             cmd,
	output sss_pkg::sss_sts_t                             sts,
	input  logic [SAMPLE_BITS-1:0]                        sample,
	input  logic [sss_pkg::NUM_REGS-1:0][SAMPLE_BITS-1:0] cfg,
	input  logic                                          m_tready,
	output logic                                          out_valid,
	output logic [2:0]                                    out_status,
	output logic [COUNT_BITS-1:0]                         out_count,
	output logic [SAMPLE_BITS-1:0]                        out_mean,
	output logic [SAMPLE_BITS-1:0]                        out_max,
	output logic [SAMPLE_BITS-1:0]                        out_min,
	output logic [COUNT_BITS-1:0]                         out_frost,
	output logic [COUNT_BITS-1:0]                         out_heat,
	output logic [SAMPLE_BITS-1:0]                        out_span,
	output logic [SAMPLE_BITS-1:0]                        out_rise,
	output logic [2:0]                                    out_class
);
	import sss_pkg::*;

	localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
	localparam int PROD_W = SUM_W + 1;

	// running statistics
	logic [SUM_W-1:0]       sum_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [COUNT_BITS-1:0]  frost_q;
	logic [COUNT_BITS-1:0]  heat_q;
	logic [SAMPLE_BITS-1:0] best_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic                   have_prev_q;

	logic signed [SAMPLE_BITS-1:0] smp;
	logic                          in_window;
	logic                          cnt_full;
	logic                          take;
	logic [COUNT_BITS-1:0]         count_inc;
	logic signed [SAMPLE_BITS:0]   rise_d;
	logic                          rise_gt;
	logic                          clear;

	// class compare
	logic signed [SAMPLE_BITS-1:0] limit_sel;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [PROD_W-1:0]      sum_ext;
	logic                          hit;
	logic [2:0]                    cls_q;

	// mean
	logic                   sum_neg;
	logic [SUM_W-1:0]       sum_mag;
	logic [SUM_W-1:0]       quot;
	logic                   div_busy;
	logic [SUM_W-1:0]       mean_full;

	logic out_valid_q;
	logic out_free;

	assign smp       = $signed(sample);
	assign in_window = (smp >= $signed(cfg[REG_VALID_LOW])) &&
	                   (smp <= $signed(cfg[REG_VALID_HIGH]));
	assign cnt_full  = &count_q;
	assign take      = cmd.sample_step && in_window && !cnt_full;
	assign count_inc = count_q + 1'b1;
	assign rise_d    = $signed({smp[SAMPLE_BITS-1], smp}) -
	                   $signed({prev_q[SAMPLE_BITS-1], prev_q});
	assign rise_gt   = have_prev_q && !rise_d[SAMPLE_BITS] &&
	                   (rise_d[SAMPLE_BITS-1:0] > best_q);
	assign clear     = cmd.report || cmd.empty_rep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			max_q       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			min_q       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			frost_q     <= '0;
			heat_q      <= '0;
			best_q      <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (clear) begin
			sum_q       <= '0;
			count_q     <= '0;
			max_q       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			min_q       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			frost_q     <= '0;
			heat_q      <= '0;
			best_q      <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (take) begin
			sum_q   <= sum_q + {{COUNT_BITS{smp[SAMPLE_BITS-1]}}, smp};
			count_q <= count_inc;
			if (smp > $signed(max_q)) begin
				max_q <= smp;
			end
			if (smp < $signed(min_q)) begin
				min_q <= smp;
			end
			if (smp < $signed(cfg[REG_FROST_BELOW])) begin
				frost_q <= frost_q + 1'b1;
			end
			if (smp > $signed(cfg[REG_HEAT_ABOVE])) begin
				heat_q <= heat_q + 1'b1;
			end
			if (rise_gt) begin
				best_q <= rise_d[SAMPLE_BITS-1:0];
			end
			prev_q      <= smp;
			have_prev_q <= 1'b1;
		end
	end

	// class: exact quotient against each limit, sum < limit*n then sum <= limit*n
	always_comb begin
		case (cmd.cls_idx)
			2'd0:    limit_sel = $signed(cfg[REG_FREEZING_LIMIT]);
			2'd1:    limit_sel = $signed(cfg[REG_COOL_LIMIT]);
			2'd2:    limit_sel = $signed(cfg[REG_MILD_LIMIT]);
			2'd3:    limit_sel = $signed(cfg[REG_WARM_LIMIT]);
			default: limit_sel = $signed(cfg[REG_WARM_LIMIT]);
		endcase
	end

	assign sum_ext = $signed({sum_q[SUM_W-1], sum_q});
	assign hit     = (cmd.cls_idx == CLS_FIRST_IDX) ? (sum_ext < prod_q) : (sum_ext <= prod_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= limit_sel * $signed({1'b0, count_q});
		end
		if (cmd.cmp) begin
			cls_q <= hit ? {1'b0, cmd.cls_idx} : CLASS_HOT;
		end
	end

	assign sum_neg = sum_q[SUM_W-1];
	assign sum_mag = sum_neg ? (~sum_q + 1'b1) : sum_q;

	sss_div #(
		.DIVIDEND_W(SUM_W),
		.DIVISOR_W (COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_mag),
		.divisor  (count_q),
		.quotient (quot),
		.busy     (div_busy)
	);

	assign mean_full = sum_neg ? (~quot + 1'b1) : quot;

	// output word register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.sample_step || clear) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sample_step) begin
			if (!in_window) begin
				out_status <= STAT_RANGE;
			end else if (cnt_full) begin
				out_status <= STAT_FULL;
			end else begin
				out_status <= STAT_ACCEPTED;
			end
			out_count <= take ? count_inc : count_q;
			out_mean  <= '0;
			out_max   <= '0;
			out_min   <= '0;
			out_frost <= '0;
			out_heat  <= '0;
			out_span  <= '0;
			out_rise  <= '0;
			out_class <= '0;
		end else if (cmd.empty_rep) begin
			out_status <= STAT_EMPTY;
			out_count  <= '0;
			out_mean   <= '0;
			out_max    <= '0;
			out_min    <= '0;
			out_frost  <= '0;
			out_heat   <= '0;
			out_span   <= '0;
			out_rise   <= '0;
			out_class  <= '0;
		end else if (cmd.report) begin
			out_status <= STAT_REPORT;
			out_count  <= count_q;
			out_mean   <= mean_full[SAMPLE_BITS-1:0];
			out_max    <= max_q;
			out_min    <= min_q;
			out_frost  <= frost_q;
			out_heat   <= heat_q;
			out_span   <= max_q - min_q;
			out_rise   <= best_q;
			out_class  <= cls_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.count_zero = (count_q == '0);
	assign sts.out_free   = out_free;
	assign sts.cls_hit    = hit;
	assign sts.div_busy   = div_busy;

endmodule

// File: sv/sensor_series_statistics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_series_statistics_unit
// Windowed running min/max/mean statistics over a temperature sample series.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. A sample word is answered
// from the result register in the cycle after it is taken, so samples stream
// at one per cycle while the output side keeps up; the result register lets
// the next word in while the last result is still being taken. An
// end-of-series word with no accepted samples is answered the same way. An
// end word with samples starts the bit-serial mean divider, which gives one
// quotient bit per cycle, and its report waits until the divider is done; the
// class decision runs meanwhile on the shared limit multiplier. No input is
// taken until that report has been loaded.
`include "sensor_series_statistics_unit_macros.svh"

module sensor_series_statistics_unit #(
	parameter int SAMPLE_BITS = 12,
	parameter int COUNT_BITS  = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// configuration
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [sss_pkg::ADDR_W-1:0]                paddr,
	input  logic [31:0]                               pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready,
	// input stream
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,  // sample
	input  logic                                      s_tuser,  // kind
	// result stream
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// valid_count, mean_value, max_value, min_value, frost_count,
	// heat_count, span, max_rise, weather_class
	output logic [((3*COUNT_BITS+5*SAMPLE_BITS+3+7)/8)*8-1:0] m_tdata,
	output logic [2:0]                                m_tuser   // status
);
	import sss_pkg::*;

	localparam int OUT_RAW_W  = 3*COUNT_BITS + 5*SAMPLE_BITS + 3;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	logic [NUM_REGS-1:0][SAMPLE_BITS-1:0] cfg;
	sss_cmd_t                             cmd;
	sss_sts_t                             sts;

	logic [2:0]             out_status;
	logic [COUNT_BITS-1:0]  out_count;
	logic [SAMPLE_BITS-1:0] out_mean;
	logic [SAMPLE_BITS-1:0] out_max;
	logic [SAMPLE_BITS-1:0] out_min;
	logic [COUNT_BITS-1:0]  out_frost;
	logic [COUNT_BITS-1:0]  out_heat;
	logic [SAMPLE_BITS-1:0] out_span;
	logic [SAMPLE_BITS-1:0] out_rise;
	logic [2:0]             out_class;

	sss_regs #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sss_dp #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.sample     (s_tdata[SAMPLE_BITS-1:0]),
		.cfg        (cfg),
		.m_tready   (m_tready),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_count  (out_count),
		.out_mean   (out_mean),
		.out_max    (out_max),
		.out_min    (out_min),
		.out_frost  (out_frost),
		.out_heat   (out_heat),
		.out_span   (out_span),
		.out_rise   (out_rise),
		.out_class  (out_class)
	);

	assign m_tuser = out_status;
	assign m_tdata = OUT_DATA_W'({out_class, out_rise, out_span, out_heat, out_frost,
	                             out_min, out_max, out_mean, out_count});

	// input is only taken when the result register has room
	`SSS_ASSERT_IMP(a_ready_room, clk, arst_n, s_tready, sts.out_free)
	// a sample word is answered on the next cycle
	`SSS_ASSERT_NXT(a_sample_answer, clk, arst_n, s_tvalid && s_tready && !s_tuser, m_tvalid)
	// an end word either reports at once or holds off input while it works
	`SSS_ASSERT_NXT(a_end_hold, clk, arst_n, s_tvalid && s_tready && s_tuser, m_tvalid || !s_tready)
	// the mean is never latched while the divider is still running
	`SSS_ASSERT_IMP(a_report_div_done, clk, arst_n, cmd.report, !sts.div_busy)

endmodule

// File: verif/series_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// series_stats_checker
// Watches the register port and both streams of the sensor series statistics
// unit. It keeps its own series statistics and one expected result per input
// word, and compares every result word with the oldest expectation, field by
// field.
// ----------------------------------------------------------------------------
module series_stats_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sss_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [15:0]                s_tdata,  // sample
	input  logic                       s_tuser,  // kind
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	// valid_count, mean_value, max_value, min_value, frost_count,
	// heat_count, span, max_rise, weather_class
	input  logic [111:0]               m_tdata,
	input  logic [2:0]                 m_tuser,  // status
	output int                         fail_count,
	output int                         pending_words
);
	import sss_pkg::*;

	localparam logic [2:0]  CLS_FREEZING = 3'd0;
	localparam logic [2:0]  CLS_COOL     = 3'd1;
	localparam logic [2:0]  CLS_MILD     = 3'd2;
	localparam logic [2:0]  CLS_WARM     = 3'd3;
	localparam logic [15:0] COUNT_FULL   = 16'hFFFF;

	typedef struct {
		logic [2:0]         status;
		logic [15:0]        count;
		logic signed [11:0] mean;
		logic signed [11:0] hi;
		logic signed [11:0] lo;
		logic [15:0]        frost;
		logic [15:0]        heat;
		logic [11:0]        span;
		logic [11:0]        rise;
		logic [2:0]         cls;
	} series_report_t;

	logic signed [11:0] thresholds [NUM_REGS];
	logic signed [27:0] sum_acc;
	logic [15:0]        n_acc;
	logic [15:0]        frost_n;
	logic [15:0]        heat_n;
	logic signed [11:0] peak;
	logic signed [11:0] trough;
	logic signed [11:0] last_sample;
	logic [11:0]        top_rise;
	logic               last_valid;
	series_report_t     report_queue [$];

	task automatic clear_series();
		sum_acc     = '0;
		n_acc       = '0;
		frost_n     = '0;
		heat_n      = '0;
		peak        = 12'sh800;
		trough      = 12'sh7FF;
		last_sample = '0;
		top_rise    = '0;
		last_valid  = 1'b0;
	endtask

	task automatic predict_word(input logic kind, input logic signed [11:0] s,
			output series_report_t r);
		longint n;
		longint tot;
		longint rise;
		r = '{default: '0};
		if (kind == KIND_SAMPLE) begin
			if (s < thresholds[REG_VALID_LOW] || s > thresholds[REG_VALID_HIGH]) begin
				r.status = STAT_RANGE;
			end else if (n_acc == COUNT_FULL) begin
				r.status = STAT_FULL;
			end else begin
				n_acc   = n_acc + 1'b1;
				sum_acc = sum_acc + s;
				if (s > peak) peak = s;
				if (s < trough) trough = s;
				if (s < thresholds[REG_FROST_BELOW]) frost_n = frost_n + 1'b1;
				if (s > thresholds[REG_HEAT_ABOVE]) heat_n = heat_n + 1'b1;
				if (last_valid) begin
					rise = longint'(s) - longint'(last_sample);
					if (rise > longint'(top_rise)) top_rise = 12'(rise);
				end
				last_sample = s;
				last_valid  = 1'b1;
				r.status    = STAT_ACCEPTED;
			end
			r.count = n_acc;
		end else begin
			if (n_acc == '0) begin
				r.status = STAT_EMPTY;
			end else begin
				n        = longint'(n_acc);
				tot      = longint'(sum_acc);
				r.status = STAT_REPORT;
				r.count  = n_acc;
				r.mean   = 12'(tot / n);
				r.hi     = peak;
				r.lo     = trough;
				r.frost  = frost_n;
				r.heat   = heat_n;
				r.span   = 12'(peak - trough);
				r.rise   = top_rise;
				// class uses the exact quotient, not the truncated mean
				if (tot < longint'(thresholds[REG_FREEZING_LIMIT]) * n) r.cls = CLS_FREEZING;
				else if (tot <= longint'(thresholds[REG_COOL_LIMIT]) * n) r.cls = CLS_COOL;
				else if (tot <= longint'(thresholds[REG_MILD_LIMIT]) * n) r.cls = CLS_MILD;
				else if (tot <= longint'(thresholds[REG_WARM_LIMIT]) * n) r.cls = CLS_WARM;
				else r.cls = CLASS_HOT;
			end
			clear_series();
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		series_report_t want;
		series_report_t got;
		if (!arst_n) begin
			clear_series();
			for (int i = 0; i < NUM_REGS; i++) thresholds[i] = 12'(REG_RESET[i]);
			report_queue.delete();
			fail_count    = 0;
			pending_words = 0;
		end else begin
			// result side first, so a stray word never meets this cycle's input
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.count  = m_tdata[15:0];
				got.mean   = m_tdata[27:16];
				got.hi     = m_tdata[39:28];
				got.lo     = m_tdata[51:40];
				got.frost  = m_tdata[67:52];
				got.heat   = m_tdata[83:68];
				got.span   = m_tdata[95:84];
				got.rise   = m_tdata[107:96];
				got.cls    = m_tdata[110:108];
				if (report_queue.size() == 0) begin
					$error("result word with none expected, status %0d", m_tuser);
					fail_count++;
				end else begin
					want = report_queue.pop_front();
					check_field("status", want.status, got.status);
					check_field("valid_count", want.count, got.count);
					check_field("mean_value", want.mean, got.mean);
					check_field("max_value", want.hi, got.hi);
					check_field("min_value", want.lo, got.lo);
					check_field("frost_count", want.frost, got.frost);
					check_field("heat_count", want.heat, got.heat);
					check_field("span", want.span, got.span);
					check_field("max_rise", want.rise, got.rise);
					check_field("weather_class", want.cls, got.cls);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_word(s_tuser, s_tdata[11:0], want);
				report_queue.push_back(want);
			end
			if (psel && penable && pwrite && pready)
				thresholds[paddr[4:2]] = pwdata[11:0];
			pending_words = report_queue.size();
		end
	end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sensor series statistics unit: directed series at the
// window and threshold edges, then random series under several register
// settings with random gaps on both streams and one long hold-off on the
// result side. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
	import sss_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_WORDS = 1750;
	localparam int PHASES       = 10;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata  = '0;
	logic              s_tuser  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [111:0]      m_tdata;
	logic [2:0]        m_tuser;

	int fail_count;
	int pending_words;
	int cycle_count = 0;
	int words_sent  = 0;
	int cfg_next [NUM_REGS];
	bit src_calm     = 1'b0;
	bit sink_calm    = 1'b0;
	bit hold_request = 1'b0;

	always #5 clk = ~clk;

	sensor_series_statistics_unit u_top (.*);

	series_stats_checker u_checker (.*);

	// mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(1, 2);
		if (r < 92) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic int series_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 0;
		if (r < 85) return $urandom_range(1, 12);
		return $urandom_range(13, 60);
	endfunction

	task automatic send_word(input logic kind, input int value);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'b0, 12'(value)};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		gap = (src_calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
	endtask

	task automatic write_regs(input int lo, hi, frost, heat, frz, cool, mild, warm);
		cfg_next[REG_VALID_LOW]      = lo;
		cfg_next[REG_VALID_HIGH]     = hi;
		cfg_next[REG_FROST_BELOW]    = frost;
		cfg_next[REG_HEAT_ABOVE]     = heat;
		cfg_next[REG_FREEZING_LIMIT] = frz;
		cfg_next[REG_COOL_LIMIT]     = cool;
		cfg_next[REG_MILD_LIMIT]     = mild;
		cfg_next[REG_WARM_LIMIT]     = warm;
		for (int i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= ADDR_W'(4 * i);
			pwdata  <= 32'(cfg_next[i]);
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic random_config(input bit unordered);
		int lo;
		int hi;
		int span;
		int lim [4];
		lo   = int'($urandom_range(0, 3000)) - 2048;
		hi   = lo + int'($urandom_range(1, 2047 - lo));
		span = hi - lo;
		for (int i = 0; i < 4; i++) begin
			if (unordered) lim[i] = int'($urandom_range(0, 4095)) - 2048;
			else lim[i] = lo + span * (i + 1) / 5 + int'($urandom_range(0, 10)) - 5;
			if (lim[i] > 2047) lim[i] = 2047;
			if (lim[i] < -2048) lim[i] = -2048;
		end
		write_regs(lo, hi, lo + int'($urandom_range(0, span)), lo + int'($urandom_range(0, span)),
			lim[0], lim[1], lim[2], lim[3]);
	endtask

	// mostly in-window samples, some at the edges, some anywhere
	task automatic send_series(input int len);
		int lo;
		int hi;
		int v;
		int r;
		lo = cfg_next[REG_VALID_LOW];
		hi = cfg_next[REG_VALID_HIGH];
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 80 && lo <= hi) v = lo + int'($urandom_range(0, hi - lo));
			else if (r < 90) v = (r[0] ? lo : hi) + int'($urandom_range(0, 4)) - 2;
			else v = int'($urandom_range(0, 4095)) - 2048;
			if (v > 2047) v = 2047;
			if (v < -2048) v = -2048;
			send_word(KIND_SAMPLE, v);
		end
		send_word(KIND_END, int'($urandom_range(0, 4095)));
	endtask

	// result side: random ready, a calm mode, and one long hold-off on request
	initial begin : sink
		int run;
		run = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request <= 1'b0;
				m_tready     <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				run = 0;
			end else if (sink_calm) begin
				m_tready <= 1'b1;
			end else if (run > 0) begin
				run--;
			end else if ($urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				run = $urandom_range(0, 15);
			end else begin
				m_tready <= 1'b0;
				run = gap_len() - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int target;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: empty report, window and threshold edges
		send_word(KIND_END, 0);
		send_word(KIND_SAMPLE, -800);
		send_word(KIND_SAMPLE, 800);
		send_word(KIND_SAMPLE, -801);
		send_word(KIND_SAMPLE, 801);
		send_word(KIND_SAMPLE, 0);
		send_word(KIND_SAMPLE, -1);
		send_word(KIND_SAMPLE, 480);
		send_word(KIND_SAMPLE, 481);
		send_word(KIND_END, 12'hABC);
		// rejected word in the middle must not move the rise baseline
		send_word(KIND_SAMPLE, 100);
		send_word(KIND_SAMPLE, 50);
		send_word(KIND_SAMPLE, 2047);
		send_word(KIND_SAMPLE, 400);
		send_word(KIND_END, 0);
		// negative mean truncates toward zero
		send_word(KIND_SAMPLE, -3);
		send_word(KIND_SAMPLE, -4);
		send_word(KIND_END, 0);

		wait_drained();
		write_regs(-2048, 2047, -2048, 2047, -2048, -2048, 2047, 2047);
		send_word(KIND_SAMPLE, -2048);
		send_word(KIND_SAMPLE, 2047);
		send_word(KIND_END, 0);

		// inverted window rejects everything
		wait_drained();
		write_regs(100, -100, 0, 0, 0, 0, 0, 0);
		send_word(KIND_SAMPLE, 0);
		send_word(KIND_END, 0);

		// narrowed window: top of range rejected, then one accepted
		wait_drained();
		write_regs(-2048, 100, 2047, -2048, 0, 240, 400, 560);
		send_word(KIND_SAMPLE, 2047);
		send_word(KIND_SAMPLE, 0);
		send_word(KIND_END, 0);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			if (p == 0) write_regs(-2048, 2047, -2048, 2047, -2048, -2048, 2047, 2047);
			else if (p == 5) write_regs(-2048, 2047, 2047, -2048, 2047, 2047, 2047, 2047);
			else random_config(p % 4 == 1);
			src_calm  <= (p % 4 == 2) || (p == 3);
			sink_calm <= (p % 4 == 2);
			// hold the result side while words keep coming, so the input stalls
			if (p == 3) hold_request <= 1'b1;
			target = words_sent + RANDOM_WORDS / PHASES;
			while (words_sent < target) send_series(series_len());
		end

		wait_drained();
		sink_calm <= 1'b1;
		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending_words == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
